### hw/rtl/ucb1_pkg.sv
// Shared constants, codes and types of the UCB1 arm selector.
`default_nettype none

package ucb1_pkg;

    localparam int ARMS_DEF       = 64;
    localparam int COUNT_BITS_DEF = 16;

    localparam int ACTION_W    = 2;
    localparam int REWARD_W    = 17;
    localparam int ARM_W       = 6;
    localparam int ARM_COUNT_W = 7;
    localparam int WEIGHT_W    = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int MEAN_W      = 17;
    localparam int FRAC_BITS   = 16;
    localparam int WEIGHT_FRAC = 12;
    localparam int SQ_CNT_W    = 4;

    localparam logic [ACTION_W-1:0] ACT_START  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REWARD = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FINISH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ARM_COUNT      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_WEIGHT = 1'b1;

    localparam logic [ARM_COUNT_W-1:0] ARM_COUNT_RST = 7'd1;
    localparam logic [WEIGHT_W-1:0]    WEIGHT_RST    = 16'd5793;

    localparam logic [REWARD_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [31:0]         LN2_Q32 = 32'd2977044472;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD_LAST,
        ST_UPDATE,
        ST_LN_LOAD,
        ST_LN_NORM,
        ST_SQ_MUL,
        ST_SQ_FIX,
        ST_LN_MUL,
        ST_SCAN_INIT,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DIV_MEAN,
        ST_DIV_RATIO,
        ST_SQRT,
        ST_NEXT,
        ST_SET_LAST,
        ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_TAKE,
        OP_CLEAR,
        OP_RD_LAST,
        OP_UPDATE,
        OP_LN_LOAD,
        OP_LN_NORM,
        OP_LN_MANT,
        OP_SQ_MUL,
        OP_SQ_FIX,
        OP_LN_MUL,
        OP_SCAN_INIT,
        OP_SCAN_RD,
        OP_SCAN_NEXT,
        OP_DIV_MEAN,
        OP_DIV_RATIO,
        OP_DIV_STEP,
        OP_SQRT_START,
        OP_SQRT_STEP,
        OP_SCORE_UCB,
        OP_SCORE_MEAN,
        OP_SCORE_ZERO,
        OP_PICK_UNVISITED,
        OP_SET_LAST
    } op_t;

    typedef struct packed {
        op_t  op;
        logic out_load;
        logic out_final;
    } ucb1_cmd_t;

    typedef struct packed {
        logic norm_done;
        logic sq_last;
        logic div_done;
        logic sqrt_done;
        logic cnt_zero;
        logic scan_last;
    } ucb1_stat_t;

endpackage

`default_nettype wire

### hw/rtl/ucb1_if.sv
// Request and response channel interfaces of the UCB1 arm selector.
`default_nettype none

interface ucb1_req_if
    import ucb1_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [REWARD_W-1:0] reward;

    modport source (output valid, output action, output reward, input ready);
    modport sink   (input valid, input action, input reward, output ready);
endinterface

interface ucb1_rsp_if
    import ucb1_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ARM_W-1:0] chosen_arm;
    logic             is_final;

    modport source (output valid, output chosen_arm, output is_final, input ready);
    modport sink   (input valid, input chosen_arm, input is_final, output ready);
endinterface

`default_nettype wire

### hw/rtl/ucb1_ctrl.sv
// Sequencer of the UCB1 arm selector: steps the datapath through each word.
`default_nettype none

module ucb1_ctrl
    import ucb1_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic                out_free,
    input  wire ucb1_stat_t          stat,
    output logic                     in_ready,
    output ucb1_cmd_t                cmd
);

    state_t state_reg, state_next;
    logic   fin_reg, fin_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        fin_next   = fin_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    unique case (action)
                        ACT_START: begin
                            state_next = ST_CLEAR;
                            fin_next   = 1'b0;
                        end
                        ACT_REWARD: begin
                            state_next = ST_RD_LAST;
                            fin_next   = 1'b0;
                        end
                        ACT_FINISH: begin
                            state_next = ST_SCAN_INIT;
                            fin_next   = 1'b1;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:     state_next = ST_DONE;
            ST_RD_LAST:   state_next = ST_UPDATE;
            ST_UPDATE:    state_next = ST_LN_LOAD;
            ST_LN_LOAD:   state_next = ST_LN_NORM;
            ST_LN_NORM:   if (stat.norm_done) state_next = ST_SQ_MUL;
            ST_SQ_MUL:    state_next = ST_SQ_FIX;
            ST_SQ_FIX:    state_next = stat.sq_last ? ST_LN_MUL : ST_SQ_MUL;
            ST_LN_MUL:    state_next = ST_SCAN_INIT;
            ST_SCAN_INIT: state_next = ST_SCAN_RD;
            ST_SCAN_RD:   state_next = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (!stat.cnt_zero) state_next = ST_DIV_MEAN;
                else if (fin_reg)   state_next = ST_NEXT;
                else                state_next = ST_DONE;
            end
            ST_DIV_MEAN: begin
                if (stat.div_done) state_next = fin_reg ? ST_NEXT : ST_DIV_RATIO;
            end
            ST_DIV_RATIO: if (stat.div_done) state_next = ST_SQRT;
            ST_SQRT:      if (stat.sqrt_done) state_next = ST_NEXT;
            ST_NEXT: begin
                if (!stat.scan_last) state_next = ST_SCAN_RD;
                else if (fin_reg)    state_next = ST_DONE;
                else                 state_next = ST_SET_LAST;
            end
            ST_SET_LAST:  state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready      = 1'b0;
        cmd.op        = OP_NOP;
        cmd.out_load  = 1'b0;
        cmd.out_final = fin_reg;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) cmd.op = OP_TAKE;
            end
            ST_CLEAR:     cmd.op = OP_CLEAR;
            ST_RD_LAST:   cmd.op = OP_RD_LAST;
            ST_UPDATE:    cmd.op = OP_UPDATE;
            ST_LN_LOAD:   cmd.op = OP_LN_LOAD;
            ST_LN_NORM:   cmd.op = stat.norm_done ? OP_LN_MANT : OP_LN_NORM;
            ST_SQ_MUL:    cmd.op = OP_SQ_MUL;
            ST_SQ_FIX:    cmd.op = OP_SQ_FIX;
            ST_LN_MUL:    cmd.op = OP_LN_MUL;
            ST_SCAN_INIT: cmd.op = OP_SCAN_INIT;
            ST_SCAN_RD:   cmd.op = OP_SCAN_RD;
            ST_SCAN_CHK: begin
                if (!stat.cnt_zero) cmd.op = OP_DIV_MEAN;
                else if (fin_reg)   cmd.op = OP_SCORE_ZERO;
                else                cmd.op = OP_PICK_UNVISITED;
            end
            ST_DIV_MEAN: begin
                if (!stat.div_done) cmd.op = OP_DIV_STEP;
                else if (fin_reg)   cmd.op = OP_SCORE_MEAN;
                else                cmd.op = OP_DIV_RATIO;
            end
            ST_DIV_RATIO: cmd.op = stat.div_done ? OP_SQRT_START : OP_DIV_STEP;
            ST_SQRT:      cmd.op = stat.sqrt_done ? OP_SCORE_UCB : OP_SQRT_STEP;
            ST_NEXT:      if (!stat.scan_last) cmd.op = OP_SCAN_NEXT;
            ST_SET_LAST:  cmd.op = OP_SET_LAST;
            ST_DONE:      cmd.out_load = out_free;
            default:      cmd.op = OP_NOP;
        endcase
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (out_free && state_reg == ST_DONE))
        else $error("result loaded while output register is full");

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && action == ACT_REWARD) |=> state_reg == ST_RD_LAST)
        else $error("reward word did not start with the credit read");

endmodule

`default_nettype wire

### hw/rtl/ucb1_dp.sv
// Datapath of the UCB1 arm selector: arm statistics, log, divider, root, scoring.
`default_nettype none

module ucb1_dp
    import ucb1_pkg::*;
#(
    parameter int ARMS       = ARMS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ucb1_cmd_t              cmd,
    input  wire logic [REWARD_W-1:0]    reward,
    input  wire logic [ARM_COUNT_W-1:0] arm_count,
    input  wire logic [WEIGHT_W-1:0]    explore_weight,
    output ucb1_stat_t                  stat,
    output logic [$clog2(ARMS)-1:0]     best_arm
);

    localparam int IDX_W    = $clog2(ARMS);
    localparam int SUM_W    = COUNT_BITS + REWARD_W;
    localparam int E_W      = $clog2(COUNT_BITS);
    localparam int LG_W     = E_W + FRAC_BITS;
    localparam int RATIO_W  = LG_W + FRAC_BITS;
    localparam int DIV_W    = (SUM_W > RATIO_W) ? SUM_W : RATIO_W;
    localparam int DC_W     = $clog2(DIV_W + 1);
    localparam int SQ_W     = RATIO_W + (RATIO_W % 2);
    localparam int ROOT_W   = SQ_W / 2;
    localparam int PROD_W   = WEIGHT_W + ROOT_W;
    localparam int SCORE_W  = PROD_W - WEIGHT_FRAC + 1;
    localparam int CW       = (IDX_W + 1 > ARM_COUNT_W) ? IDX_W + 1 : ARM_COUNT_W;
    localparam int MANT_PAD = 32 - COUNT_BITS;
    localparam int LNP_W    = LG_W + 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SQ_CNT_W-1:0]   SQ_LAST   = SQ_CNT_W'(FRAC_BITS - 1);

    op_t op;
    assign op = cmd.op;

    // statistics memories; valid bits give the cleared value
    logic [COUNT_BITS-1:0] mem_cnt [ARMS];
    logic [SUM_W-1:0]      mem_sum [ARMS];
    logic [ARMS-1:0]       vld_reg;
    logic [COUNT_BITS-1:0] rd_cnt_reg;
    logic [SUM_W-1:0]      rd_sum_reg;
    logic                  rd_vld_reg;

    logic [REWARD_W-1:0]   rew_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic [IDX_W-1:0]      last_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [IDX_W-1:0]      scan_idx_reg;
    logic                  first_reg;
    logic [SCORE_W-1:0]    best_score_reg;

    logic [COUNT_BITS-1:0] t_reg;
    logic [E_W-1:0]        e_reg;
    logic                  tz_reg;
    logic [31:0]           m_reg;
    logic [63:0]           sqp_reg;
    logic [SQ_CNT_W-1:0]   sq_cnt_reg;
    logic [FRAC_BITS-1:0]  frac_reg;
    logic [LG_W-1:0]       ln_reg;

    logic [DIV_W-1:0]      q_reg, q_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [COUNT_BITS-1:0] d_reg;
    logic [DC_W-1:0]       dc_reg;
    logic [MEAN_W-1:0]     mean_reg;

    logic [SQ_W-1:0]       x_reg, x_next;
    logic [SQ_W-1:0]       r_reg, r_next;
    logic [SQ_W-1:0]       bit_reg;

    logic [IDX_W-1:0]      rd_addr;
    logic [COUNT_BITS-1:0] eff_cnt;
    logic [SUM_W-1:0]      eff_sum;
    logic [IDX_W-1:0]      k_last;
    logic [CW-1:0]         ac_ext;
    logic [32:0]           sq_top;
    logic [LNP_W-1:0]      ln_prod;
    logic [COUNT_BITS:0]   div_rs;
    logic                  div_ge;
    logic [SQ_W:0]         sq_rb;
    logic                  sq_ge;
    logic [PROD_W-1:0]     bprod;
    logic [SCORE_W-1:0]    cand;
    logic                  take_cand;

    assign rd_addr = (op == OP_RD_LAST) ? last_reg : scan_idx_reg;
    assign eff_cnt = rd_vld_reg ? rd_cnt_reg : '0;
    assign eff_sum = rd_vld_reg ? rd_sum_reg : '0;

    // last arm scanned: arm_count clamped to 1..ARMS
    assign ac_ext = CW'(arm_count);
    always_comb begin
        if (ac_ext == '0)             k_last = '0;
        else if (ac_ext > CW'(ARMS))  k_last = IDX_W'(ARMS - 1);
        else                          k_last = IDX_W'(ac_ext - CW'(1));
    end

    assign sq_top  = sqp_reg[63:31];
    assign ln_prod = LNP_W'({e_reg, frac_reg}) * LNP_W'(LN2_Q32);

    // restoring divider, one quotient bit a cycle
    assign div_rs   = {rem_reg, q_reg[DIV_W-1]};
    assign div_ge   = div_rs >= {1'b0, d_reg};
    assign rem_next = div_ge ? COUNT_BITS'(div_rs - {1'b0, d_reg}) : div_rs[COUNT_BITS-1:0];
    assign q_next   = {q_reg[DIV_W-2:0], div_ge};

    // bit-serial integer square root
    assign sq_rb  = (SQ_W+1)'(r_reg) + (SQ_W+1)'(bit_reg);
    assign sq_ge  = (SQ_W+1)'(x_reg) >= sq_rb;
    assign x_next = sq_ge ? SQ_W'((SQ_W+1)'(x_reg) - sq_rb) : x_reg;
    assign r_next = sq_ge ? (r_reg >> 1) + bit_reg : r_reg >> 1;

    assign bprod = PROD_W'(explore_weight) * PROD_W'(r_reg[ROOT_W-1:0]);

    always_comb begin
        case (op)
            OP_SCORE_UCB:  cand = SCORE_W'(mean_reg) + SCORE_W'(bprod[PROD_W-1:WEIGHT_FRAC]);
            OP_SCORE_MEAN: cand = SCORE_W'(q_reg[MEAN_W-1:0]);
            default:       cand = '0;
        endcase
    end
    assign take_cand = first_reg || (cand > best_score_reg);

    // memory ports
    always_ff @(posedge clk) begin
        if (op == OP_UPDATE && eff_cnt != COUNT_MAX) begin
            mem_cnt[last_reg] <= eff_cnt + COUNT_BITS'(1);
            mem_sum[last_reg] <= eff_sum + SUM_W'(rew_reg);
        end
        if (op == OP_RD_LAST || op == OP_SCAN_RD) begin
            rd_cnt_reg <= mem_cnt[rd_addr];
            rd_sum_reg <= mem_sum[rd_addr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            total_reg    <= '0;
            last_reg     <= '0;
            best_idx_reg <= '0;
            dc_reg       <= '0;
            bit_reg      <= '0;
            r_reg        <= '0;
        end else begin
            case (op)
                OP_CLEAR: begin
                    vld_reg      <= '0;
                    total_reg    <= '0;
                    last_reg     <= '0;
                    best_idx_reg <= '0;
                end
                OP_RD_LAST, OP_SCAN_RD: rd_vld_reg <= vld_reg[rd_addr];
                OP_UPDATE: begin
                    vld_reg[last_reg] <= 1'b1;
                    if (total_reg != COUNT_MAX) total_reg <= total_reg + COUNT_BITS'(1);
                end
                OP_DIV_MEAN, OP_DIV_RATIO: dc_reg <= DC_W'(DIV_W);
                OP_DIV_STEP: dc_reg <= dc_reg - DC_W'(1);
                OP_SQRT_START: begin
                    r_reg   <= '0;
                    bit_reg <= SQ_W'(1) << (SQ_W - 2);
                end
                OP_SQRT_STEP: begin
                    r_reg   <= r_next;
                    bit_reg <= bit_reg >> 2;
                end
                OP_SCORE_UCB, OP_SCORE_MEAN, OP_SCORE_ZERO: begin
                    if (take_cand) best_idx_reg <= scan_idx_reg;
                end
                OP_PICK_UNVISITED: begin
                    best_idx_reg <= scan_idx_reg;
                    last_reg     <= scan_idx_reg;
                end
                OP_SET_LAST: last_reg <= best_idx_reg;
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk) begin
        case (op)
            OP_TAKE: rew_reg <= (reward > ONE_Q16) ? ONE_Q16 : reward;
            OP_LN_LOAD: begin
                t_reg  <= total_reg;
                e_reg  <= E_W'(COUNT_BITS - 1);
                tz_reg <= (total_reg == '0);
            end
            OP_LN_NORM: begin
                t_reg <= t_reg << 1;
                e_reg <= e_reg - E_W'(1);
            end
            OP_LN_MANT: begin
                m_reg      <= {t_reg, {MANT_PAD{1'b0}}};
                sq_cnt_reg <= '0;
                frac_reg   <= '0;
            end
            OP_SQ_MUL: sqp_reg <= 64'(m_reg) * 64'(m_reg);
            OP_SQ_FIX: begin
                frac_reg   <= {frac_reg[FRAC_BITS-2:0], sq_top[32]};
                m_reg      <= sq_top[32] ? sq_top[32:1] : sq_top[31:0];
                sq_cnt_reg <= sq_cnt_reg + SQ_CNT_W'(1);
            end
            OP_LN_MUL: ln_reg <= tz_reg ? '0 : ln_prod[LNP_W-1:32];
            OP_SCAN_INIT: begin
                scan_idx_reg <= '0;
                first_reg    <= 1'b1;
            end
            OP_SCAN_NEXT: scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            OP_DIV_MEAN: begin
                q_reg   <= DIV_W'(eff_sum);
                rem_reg <= '0;
                d_reg   <= eff_cnt;
            end
            OP_DIV_RATIO: begin
                mean_reg <= q_reg[MEAN_W-1:0];
                q_reg    <= DIV_W'({ln_reg, {FRAC_BITS{1'b0}}});
                rem_reg  <= '0;
            end
            OP_DIV_STEP: begin
                q_reg   <= q_next;
                rem_reg <= rem_next;
            end
            OP_SQRT_START: x_reg <= SQ_W'(q_reg[RATIO_W-1:0]);
            OP_SQRT_STEP:  x_reg <= x_next;
            OP_SCORE_UCB, OP_SCORE_MEAN, OP_SCORE_ZERO: begin
                first_reg <= 1'b0;
                if (take_cand) best_score_reg <= cand;
            end
            default: ;
        endcase
    end

    assign stat.norm_done = t_reg[COUNT_BITS-1] | tz_reg;
    assign stat.sq_last   = (sq_cnt_reg == SQ_LAST);
    assign stat.div_done  = (dc_reg == '0);
    assign stat.sqrt_done = (bit_reg == '0);
    assign stat.cnt_zero  = (eff_cnt == '0);
    assign stat.scan_last = (scan_idx_reg == k_last);
    assign best_arm       = best_idx_reg;

    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_DIV_MEAN || op == OP_DIV_RATIO) |=> !stat.div_done)
        else $error("divider reported done right after load");

    a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
        stat.sqrt_done |-> (r_reg >> ROOT_W) == '0)
        else $error("square root wider than its result field");

    a_total_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_UPDATE && total_reg == COUNT_MAX) |=> total_reg == COUNT_MAX)
        else $error("total visit count wrapped");

endmodule

`default_nettype wire

### hw/rtl/ucb1_bandit_arm_selector_top.sv
// Top level of the UCB1 arm selector: config registers, sequencer, datapath, result register.
//
//   channel  dir  handshake           word
//   req      in   req.valid/ready     action[1:0], reward[16:0] (Q1.16)
//   rsp      out  rsp.valid/ready     chosen_arm[5:0], is_final
//   cfg      in   cfg_we              cfg_index selects arm_count or explore_weight
//
// Start clears the statistics. Reward: the update and the log
// (up to 15 normalizing shifts, 16 squarings on one 32x32 multiplier), then per
// scanned visited arm a mean and a ratio division (36-step divider used twice,
// 18-step root). Finish: one mean division per scanned visited arm.
// A reset clears all statistics at once through per-arm valid bits.
// The next word is taken as soon as the result is in the output register;
// a stalled rsp holds that word and only blocks the next result load.
`default_nettype none

module ucb1_bandit_arm_selector_top
    import ucb1_pkg::*;
#(
    parameter int ARMS       = ARMS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ucb1_req_if.sink                   req,
    ucb1_rsp_if.source                 rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(ARMS);

    logic [ARM_COUNT_W-1:0] arm_count_reg;
    logic [WEIGHT_W-1:0]    weight_reg;
    logic                   out_valid_reg;
    logic [ARM_W-1:0]       out_arm_reg;
    logic                   out_final_reg;

    ucb1_cmd_t        cmd;
    ucb1_stat_t       stat;
    logic [IDX_W-1:0] best_arm;
    logic             out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            arm_count_reg <= ARM_COUNT_RST;
            weight_reg    <= WEIGHT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ARM_COUNT:      arm_count_reg <= cfg_data[ARM_COUNT_W-1:0];
                CFG_EXPLORE_WEIGHT: weight_reg    <= cfg_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // a result may load when the register is empty or drains this cycle
    assign out_free = !out_valid_reg || rsp.ready;

    ucb1_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .action   (req.action),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (req.ready),
        .cmd      (cmd)
    );

    ucb1_dp #(
        .ARMS       (ARMS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .reward         (req.reward),
        .arm_count      (arm_count_reg),
        .explore_weight (weight_reg),
        .stat           (stat),
        .best_arm       (best_arm)
    );

    // output register: hold the word until rsp takes it
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (rsp.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.out_load) begin
            out_arm_reg   <= ARM_W'(best_arm);
            out_final_reg <= cmd.out_final;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.chosen_arm = out_arm_reg;
    assign rsp.is_final   = out_final_reg;

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready &&
         (req.action == ACT_START || req.action == ACT_REWARD || req.action == ACT_FINISH))
        |=> !req.ready)
        else $error("new word taken while one is in work");

endmodule

`default_nettype wire
